/* hdl/rap_pkg.sv */
`default_nettype none
package rap_pkg;

    localparam int A_W = 48;
    localparam int B_W = 33;
    localparam int P_W = 82;

    localparam logic [1:0] MODE_INJECT = 2'd0;
    localparam logic [1:0] MODE_EMF    = 2'd1;
    localparam logic [1:0] MODE_HALL   = 2'd2;

    localparam logic [1:0] REG_LOOP_MODE   = 2'd0;
    localparam logic [1:0] REG_PROP_GAIN   = 2'd1;
    localparam logic [1:0] REG_INTEG_GAIN  = 2'd2;
    localparam logic [1:0] REG_STEP_PERIOD = 2'd3;

    localparam logic [31:0] STEP_PERIOD_RST = 32'd429497;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [31:0] TWO_PI_Q24     = 32'd105414357;
    localparam logic [31:0] LP_OLD_Q16     = 32'd58982;
    localparam logic [31:0] LP_NEW_Q16     = 32'd6554;
    localparam logic [31:0] HALL_KI_Q16    = 32'd15466;
    localparam logic [31:0] HALL_KP_Q16    = 32'd92668;

    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [P_W-1:0] init;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] x);
        logic signed [31:0] r;
        if (x > P_W'(64'sd2147483647))
            r = 32'sh7FFFFFFF;
        else if (x < -P_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] satu32(input logic signed [P_W-1:0] x);
        logic [31:0] r;
        if (x > P_W'(64'sd4294967295))
            r = 32'hFFFFFFFF;
        else
            r = x[31:0];
        return r;
    endfunction

    // sin or cos in Q2.30 of a first-quadrant argument, truncating series
    function automatic longint series_q30(input longint x, input bit is_sin);
        longint term;
        longint sum;
        longint t2;
        term = is_sin ? x : ONE_Q30;
        sum = term;
        for (int k = 1; k <= 7; k++) begin
            t2 = (((term * x) >>> 30) * x) >>> 30;
            if (is_sin) begin
                case (k)
                    1: term = t2 / 6;
                    2: term = t2 / 20;
                    3: term = t2 / 42;
                    4: term = t2 / 72;
                    5: term = t2 / 110;
                    6: term = t2 / 156;
                    default: term = t2 / 210;
                endcase
            end
            else begin
                case (k)
                    1: term = t2 / 2;
                    2: term = t2 / 12;
                    3: term = t2 / 30;
                    4: term = t2 / 56;
                    5: term = t2 / 90;
                    6: term = t2 / 132;
                    default: term = t2 / 182;
                endcase
            end
            sum = ((k % 2) == 1) ? sum - term : sum + term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return sum;
    endfunction

endpackage
`default_nettype wire

/* hdl/rap_if.sv */
`default_nettype none
interface rap_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] axis_alpha;
    logic signed [31:0] axis_beta;
    logic        [15:0] hall_angle;
    logic signed [31:0] hall_speed;

    modport source (output valid, kind, axis_alpha, axis_beta, hall_angle, hall_speed,
                    input ready);
    modport sink (input valid, kind, axis_alpha, axis_beta, hall_angle, hall_speed,
                  output ready);
endinterface

interface rap_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] angle_out;
    logic signed [31:0] speed_out;
    logic signed [31:0] error_out;

    modport source (output valid, angle_out, speed_out, error_out, input ready);
    modport sink (input valid, angle_out, speed_out, error_out, output ready);
endinterface
`default_nettype wire

/* hdl/rap_serial_mul.sv */
`default_nettype none
module rap_serial_mul
    import rap_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mul_req_t              req,
    output logic                       busy,
    output logic signed [P_W-1:0]      prod
);

    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

    logic signed [P_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [P_W-1:0] p_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    // one multiplier bit per cycle, top bit of b carries negative weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= P_W'(req.a);
            b_reg <= req.b;
            p_reg <= req.init;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                p_reg <= (cnt_reg == CNT_LAST) ? p_reg - a_reg : p_reg + a_reg;
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >>> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = p_reg;

endmodule
`default_nettype wire

/* hdl/rotor_angle_pll.sv */
`default_nettype none
// Channel | Dir | Payload                                            | Transfer
// sample  | in  | kind, axis_alpha, axis_beta, hall_angle, hall_speed | valid & ready
// result  | out | angle_out, speed_out, error_out                     | valid & ready
// cfg     | in  | cfg_index, cfg_data                                 | cfg_we
// One request at a time; every product runs on a shared bit-serial multiplier.
// Mode 1 takes one more product than mode 0; mode 2 takes nine products plus a
// square root; a clear and mode 3 take no product.
// Reset zeroes the loop state and the gains; step_period resets to 429497.
// A finished result waits in the output register while the next request is taken.
module rotor_angle_pll
    import rap_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAC_BITS        = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rap_in_if.sink          sample,
    rap_out_if.source       result,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int LOG2D = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR   = SINE_TABLE_DEPTH / 4;
    localparam int REM_W = LOG2D - 2;

    typedef logic [30:0] qtab_t [QTR];

    function automatic qtab_t build_tab(input bit is_sin);
        qtab_t  t;
        longint x;
        for (int r = 0; r < QTR; r++) begin
            x = (longint'(r) * HALF_PI_Q30) >>> REM_W;
            t[r] = 31'(series_q30(x, is_sin));
        end
        return t;
    endfunction

    localparam qtab_t SIN_TAB = build_tab(1'b1);
    localparam qtab_t COS_TAB = build_tab(1'b0);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_TAB  = 5'd1;
    localparam logic [4:0] ST_E1   = 5'd2;
    localparam logic [4:0] ST_E2   = 5'd3;
    localparam logic [4:0] ST_P    = 5'd4;
    localparam logic [4:0] ST_G    = 5'd5;
    localparam logic [4:0] ST_I    = 5'd6;
    localparam logic [4:0] ST_F1   = 5'd7;
    localparam logic [4:0] ST_F2   = 5'd8;
    localparam logic [4:0] ST_V1   = 5'd9;
    localparam logic [4:0] ST_V2   = 5'd10;
    localparam logic [4:0] ST_HE   = 5'd11;
    localparam logic [4:0] ST_HI   = 5'd12;
    localparam logic [4:0] ST_HP   = 5'd13;
    localparam logic [4:0] ST_HK1  = 5'd14;
    localparam logic [4:0] ST_HK2  = 5'd15;
    localparam logic [4:0] ST_HKI  = 5'd16;
    localparam logic [4:0] ST_HSQ  = 5'd17;
    localparam logic [4:0] ST_HKP  = 5'd18;
    localparam logic [4:0] ST_DONE = 5'd19;

    logic [4:0]  state_reg;
    logic        launched_reg;

    logic [1:0]  loop_mode_reg;
    logic [31:0] prop_gain_reg;
    logic [31:0] integ_gain_reg;
    logic [31:0] step_period_reg;

    logic [15:0]        track_angle_reg;
    logic signed [31:0] integ_acc_reg;
    logic signed [31:0] speed_raw_reg;
    logic signed [31:0] speed_smooth_reg;
    logic [31:0]        hall_prop_gain_reg;
    logic [31:0]        hall_integ_gain_reg;

    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic [15:0]        hangle_reg;
    logic signed [31:0] hspeed_reg;

    logic signed [31:0] s_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] p_reg;
    logic [31:0]        g_reg;
    logic signed [31:0] spd_reg;
    logic signed [32:0] rad_reg;
    logic signed [31:0] fin_speed_reg;
    logic [47:0]        k_reg;
    logic [63:0]        sq_v_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_bit_reg;
    logic [4:0]         sq_cnt_reg;

    logic               res_valid_reg;
    logic [15:0]        res_angle_reg;
    logic signed [31:0] res_speed_reg;
    logic signed [31:0] res_error_reg;

    mul_req_t              mreq;
    logic                  mul_busy;
    logic signed [P_W-1:0] prod;
    logic                  mul_done;
    logic                  is_mul_state;

    logic signed [P_W-1:0] sh30, shf, sh32, sh16, shv, shh;
    logic signed [31:0]    inc_sat, integ_sum, raw_sum, hall_raw, p_sat, hall_spd;
    logic [REM_W-1:0]      rem;
    logic signed [31:0]    ps, pc;
    logic [15:0]           hd;
    logic signed [16:0]    hds;
    logic [32:0]           hmag;
    logic [63:0]           sq_try;
    logic                  take_in;
    logic                  load_res;

    rap_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .busy  (mul_busy),
        .prod  (prod)
    );

    assign is_mul_state = state_reg inside {ST_E1, ST_E2, ST_P, ST_G, ST_I, ST_F1, ST_F2,
                                            ST_V1, ST_V2, ST_HE, ST_HI, ST_HP, ST_HK1,
                                            ST_HK2, ST_HKI, ST_HKP};
    assign mul_done = launched_reg && !mul_busy;

    assign sh30 = prod >>> 30;
    assign shf  = prod >>> FRAC_BITS;
    assign sh32 = prod >>> 32;
    assign sh16 = prod >>> 16;
    assign shv  = prod >>> (32 + FRAC_BITS - 16);
    assign shh  = prod >>> (40 - FRAC_BITS);

    assign inc_sat   = sat32(shf);
    assign integ_sum = sat32(P_W'(integ_acc_reg) + P_W'(inc_sat));
    assign raw_sum   = sat32(P_W'(p_reg) + P_W'(integ_sum));
    assign hall_raw  = sat32(P_W'(speed_raw_reg) + P_W'(inc_sat));
    assign p_sat     = inc_sat;
    assign hall_spd  = sat32(P_W'(speed_raw_reg) + P_W'(p_sat));

    assign rem = track_angle_reg[13 -: REM_W];
    assign ps  = {1'b0, SIN_TAB[rem]};
    assign pc  = {1'b0, COS_TAB[rem]};

    assign hd   = hangle_reg - track_angle_reg;
    assign hds  = (hd > 16'd32768) ? {1'b1, hd} : {1'b0, hd};
    assign hmag = hspeed_reg[31] ? 33'd0 - {hspeed_reg[31], hspeed_reg}
                                 : {1'b0, hspeed_reg};
    assign sq_try = sq_r_reg + sq_bit_reg;

    always_comb
    begin
        mreq.start = is_mul_state && !launched_reg;
        mreq.a     = '0;
        mreq.b     = '0;
        mreq.init  = '0;
        case (state_reg)
            ST_E1:
            begin
                mreq.a = -A_W'(alpha_reg);
                mreq.b = (loop_mode_reg == MODE_INJECT) ? B_W'(s_reg) : B_W'(c_reg);
            end
            ST_E2:
            begin
                mreq.a    = (loop_mode_reg == MODE_INJECT) ? A_W'(beta_reg) : -A_W'(beta_reg);
                mreq.b    = (loop_mode_reg == MODE_INJECT) ? B_W'(c_reg) : B_W'(s_reg);
                mreq.init = prod;
            end
            ST_P:
            begin
                mreq.a = A_W'(err_reg);
                mreq.b = {1'b0, prop_gain_reg};
            end
            ST_G:
            begin
                mreq.a = A_W'({1'b0, integ_gain_reg});
                mreq.b = {1'b0, step_period_reg};
            end
            ST_I:
            begin
                mreq.a = A_W'(err_reg);
                mreq.b = (loop_mode_reg == MODE_INJECT) ? {1'b0, integ_gain_reg}
                                                        : {1'b0, g_reg};
            end
            ST_F1:
            begin
                mreq.a = A_W'(speed_smooth_reg);
                mreq.b = {1'b0, LP_OLD_Q16};
            end
            ST_F2:
            begin
                mreq.a    = A_W'(speed_raw_reg);
                mreq.b    = {1'b0, LP_NEW_Q16};
                mreq.init = prod;
            end
            ST_V1:
            begin
                mreq.a = A_W'(spd_reg);
                mreq.b = {1'b0, step_period_reg};
            end
            ST_V2:
            begin
                mreq.a = A_W'(rad_reg);
                mreq.b = {1'b0, INV_TWO_PI_Q32};
            end
            ST_HE:
            begin
                mreq.a = A_W'(hds);
                mreq.b = {1'b0, TWO_PI_Q24};
            end
            ST_HI:
            begin
                mreq.a = A_W'(err_reg);
                mreq.b = {1'b0, hall_integ_gain_reg};
            end
            ST_HP:
            begin
                mreq.a = A_W'(err_reg);
                mreq.b = {1'b0, hall_prop_gain_reg};
            end
            ST_HK1:
            begin
                mreq.a = A_W'({1'b0, hmag});
                mreq.b = hmag;
            end
            ST_HK2:
            begin
                mreq.a = A_W'({1'b0, k_reg});
                mreq.b = {1'b0, HALL_KI_Q16};
            end
            ST_HKI:
            begin
                mreq.a = A_W'({1'b0, k_reg});
                mreq.b = {1'b0, step_period_reg};
            end
            ST_HKP:
            begin
                mreq.a = A_W'(sq_r_reg);
                mreq.b = {1'b0, HALL_KP_Q16};
            end
            default:
            begin
                mreq.a = '0;
            end
        endcase
    end

    assign take_in  = sample.valid && (state_reg == ST_IDLE);
    assign load_res = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            alpha_reg  <= sample.axis_alpha;
            beta_reg   <= sample.axis_beta;
            hangle_reg <= sample.hall_angle;
            hspeed_reg <= sample.hall_speed;
        end
        if (load_res)
        begin
            res_angle_reg <= track_angle_reg;
            res_speed_reg <= fin_speed_reg;
            res_error_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            launched_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
            loop_mode_reg       <= MODE_INJECT;
            prop_gain_reg       <= '0;
            integ_gain_reg      <= '0;
            step_period_reg     <= STEP_PERIOD_RST;
            track_angle_reg     <= '0;
            integ_acc_reg       <= '0;
            speed_raw_reg       <= '0;
            speed_smooth_reg    <= '0;
            hall_prop_gain_reg  <= '0;
            hall_integ_gain_reg <= '0;
            s_reg               <= '0;
            c_reg               <= '0;
            err_reg             <= '0;
            p_reg               <= '0;
            g_reg               <= '0;
            spd_reg             <= '0;
            rad_reg             <= '0;
            fin_speed_reg       <= '0;
            k_reg               <= '0;
            sq_v_reg            <= '0;
            sq_r_reg            <= '0;
            sq_bit_reg          <= '0;
            sq_cnt_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOOP_MODE:   loop_mode_reg   <= cfg_data[1:0];
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                    REG_STEP_PERIOD: step_period_reg <= cfg_data;
                    default:         loop_mode_reg   <= loop_mode_reg;
                endcase
            end

            if (load_res)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            if (mreq.start)
                launched_reg <= 1'b1;
            else if (mul_done)
                launched_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (take_in)
                    begin
                        err_reg <= '0;
                        if (sample.kind)
                        begin
                            integ_acc_reg    <= '0;
                            speed_raw_reg    <= '0;
                            speed_smooth_reg <= '0;
                            fin_speed_reg    <= '0;
                            state_reg        <= ST_DONE;
                        end
                        else if (loop_mode_reg == MODE_INJECT || loop_mode_reg == MODE_EMF)
                            state_reg <= ST_TAB;
                        else if (loop_mode_reg == MODE_HALL)
                            state_reg <= ST_HE;
                        else
                        begin
                            fin_speed_reg <= speed_smooth_reg;
                            state_reg     <= ST_DONE;
                        end
                    end
                end
                ST_TAB:
                begin
                    case (track_angle_reg[15:14])
                        2'd0:
                        begin
                            s_reg <= ps;
                            c_reg <= pc;
                        end
                        2'd1:
                        begin
                            s_reg <= pc;
                            c_reg <= -ps;
                        end
                        2'd2:
                        begin
                            s_reg <= -ps;
                            c_reg <= -pc;
                        end
                        default:
                        begin
                            s_reg <= -pc;
                            c_reg <= ps;
                        end
                    endcase
                    state_reg <= ST_E1;
                end
                ST_E1:
                    if (mul_done)
                        state_reg <= ST_E2;
                ST_E2:
                    if (mul_done)
                    begin
                        err_reg   <= sat32(sh30);
                        state_reg <= ST_P;
                    end
                ST_P:
                    if (mul_done)
                    begin
                        p_reg     <= p_sat;
                        state_reg <= (loop_mode_reg == MODE_EMF) ? ST_G : ST_I;
                    end
                ST_G:
                    if (mul_done)
                    begin
                        g_reg     <= sh32[31:0];
                        state_reg <= ST_I;
                    end
                ST_I:
                    if (mul_done)
                    begin
                        integ_acc_reg <= integ_sum;
                        speed_raw_reg <= raw_sum;
                        state_reg     <= ST_F1;
                    end
                ST_F1:
                    if (mul_done)
                        state_reg <= ST_F2;
                ST_F2:
                    if (mul_done)
                    begin
                        speed_smooth_reg <= sat32(sh16);
                        spd_reg          <= sat32(sh16);
                        fin_speed_reg    <= sat32(sh16);
                        state_reg        <= ST_V1;
                    end
                ST_V1:
                    if (mul_done)
                    begin
                        rad_reg   <= sh32[32:0];
                        state_reg <= ST_V2;
                    end
                ST_V2:
                    if (mul_done)
                    begin
                        track_angle_reg <= track_angle_reg + shv[15:0];
                        state_reg <= (loop_mode_reg == MODE_HALL) ? ST_HK1 : ST_DONE;
                    end
                ST_HE:
                    if (mul_done)
                    begin
                        err_reg   <= shh[31:0];
                        state_reg <= ST_HI;
                    end
                ST_HI:
                    if (mul_done)
                    begin
                        speed_raw_reg <= hall_raw;
                        fin_speed_reg <= hall_raw;
                        state_reg     <= ST_HP;
                    end
                ST_HP:
                    if (mul_done)
                    begin
                        spd_reg   <= hall_spd;
                        state_reg <= ST_V1;
                    end
                ST_HK1:
                    if (mul_done)
                    begin
                        k_reg     <= sh16[47:0];
                        state_reg <= ST_HK2;
                    end
                ST_HK2:
                    if (mul_done)
                    begin
                        k_reg     <= shf[47:0];
                        state_reg <= ST_HKI;
                    end
                ST_HKI:
                    if (mul_done)
                    begin
                        hall_integ_gain_reg <= satu32(sh32);
                        sq_v_reg   <= 64'(k_reg) << FRAC_BITS;
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_HSQ;
                    end
                ST_HSQ:
                begin
                    if (sq_v_reg >= sq_try)
                    begin
                        sq_v_reg <= sq_v_reg - sq_try;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd31)
                        state_reg <= ST_HKP;
                end
                ST_HKP:
                    if (mul_done)
                    begin
                        hall_prop_gain_reg <= satu32(sh16);
                        state_reg          <= ST_DONE;
                    end
                ST_DONE:
                    if (load_res)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign sample.ready     = (state_reg == ST_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.angle_out = res_angle_reg;
    assign result.speed_out = res_speed_reg;
    assign result.error_out = res_error_reg;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb
    import rap_pkg::*;
();

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 195;

    localparam longint INV_2PI_Q32 = 64'sd683565276;
    localparam longint TWO_PI_Q24  = 64'sd105414357;
    localparam longint LP_OLD      = 64'sd58982;
    localparam longint LP_NEW      = 64'sd6554;
    localparam longint HALL_KI     = 64'sd15466;
    localparam longint HALL_KP     = 64'sd92668;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic        [15:0] hangle;
        logic signed [31:0] hspeed;
    } sample_t;

    typedef struct packed {
        logic        [15:0] angle;
        logic signed [31:0] speed;
        logic signed [31:0] err;
    } result_t;

    typedef struct {
        bit          set_cfg;
        logic [1:0]  mode;
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] ts;
        sample_t     smp;
        bit          fixed;
        result_t     want;
    } drow_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    rap_in_if  smp_ch();
    rap_out_if res_ch();

    rotor_angle_pll uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // loop model state
    logic [1:0]  m_mode;
    logic [31:0] m_kp;
    logic [31:0] m_ki;
    logic [31:0] m_ts;
    logic [15:0] trk_angle;
    longint      integ;
    longint      spd_raw;
    longint      spd_smooth;
    logic [31:0] hall_kp;
    logic [31:0] hall_ki;

    result_t pending_results[$];
    int      fail_count = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    drow_t   dtab[$];

    always #2 clk = ~clk;

    function automatic longint clip_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] clip_u32(input logic [63:0] v);
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic longint trig_series(input longint x, input bit want_sin);
        longint term;
        longint acc;
        longint div;
        term = want_sin ? x : ONE_Q30;
        acc = term;
        for (int k = 1; k <= 7; k++)
        begin
            div = want_sin ? longint'(2 * k * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
            term = ((((term * x) >>> 30) * x) >>> 30) / div;
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0)
            acc = 0;
        if (acc > ONE_Q30)
            acc = ONE_Q30;
        return acc;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void advance_angle(input longint spd);
        longint rad;
        longint turns;
        rad = (spd * longint'({32'b0, m_ts})) >>> 32;
        turns = (rad * INV_2PI_Q32) >>> 32;
        trk_angle = trk_angle + turns[15:0];
    endfunction

    function automatic result_t loop_step(input sample_t s);
        result_t     r;
        longint      err;
        longint      spd_o;
        longint      a, b, sn, cs, x, p, inc;
        logic [9:0]  idx;
        logic [63:0] prod, mag, k, kpv;
        logic [15:0] d;
        longint      ds;
        err = 0;
        if (s.kind)
        begin
            integ = 0;
            spd_raw = 0;
            spd_smooth = 0;
            spd_o = 0;
        end
        else if (m_mode == MODE_INJECT || m_mode == MODE_EMF)
        begin
            a = longint'(s.alpha);
            b = longint'(s.beta);
            idx = trk_angle[15:6];
            x = longint'({idx[7:0], 2'b00}) * HALF_PI_Q30 / 1024;
            case (idx[9:8])
                2'd0: begin sn = trig_series(x, 1); cs = trig_series(x, 0); end
                2'd1: begin sn = trig_series(x, 0); cs = -trig_series(x, 1); end
                2'd2: begin sn = -trig_series(x, 1); cs = -trig_series(x, 0); end
                default: begin sn = -trig_series(x, 0); cs = trig_series(x, 1); end
            endcase
            if (m_mode == MODE_INJECT)
                err = clip_s32((-a * sn + b * cs) >>> 30);
            else
                err = clip_s32((-a * cs - b * sn) >>> 30);
            p = clip_s32((longint'({32'b0, m_kp}) * err) >>> 16);
            if (m_mode == MODE_INJECT)
                inc = (longint'({32'b0, m_ki}) * err) >>> 16;
            else
            begin
                prod = {32'b0, m_ki} * {32'b0, m_ts};
                inc = (longint'({32'b0, prod[63:32]}) * err) >>> 16;
            end
            integ = clip_s32(integ + clip_s32(inc));
            spd_raw = clip_s32(p + integ);
            spd_smooth = clip_s32((spd_smooth * LP_OLD + spd_raw * LP_NEW) >>> 16);
            advance_angle(spd_smooth);
            spd_o = spd_smooth;
        end
        else if (m_mode == MODE_HALL)
        begin
            d = s.hangle - trk_angle;
            ds = (d > 16'd32768) ? longint'({48'b0, d}) - 65536 : longint'({48'b0, d});
            err = (ds * TWO_PI_Q24) >>> 24;
            spd_raw = clip_s32(spd_raw + clip_s32((longint'({32'b0, hall_ki}) * err) >>> 16));
            p = clip_s32((longint'({32'b0, hall_kp}) * err) >>> 16);
            advance_angle(clip_s32(spd_raw + p));
            a = longint'(s.hspeed);
            mag = (a < 0) ? 64'(-a) : 64'(a);
            k = (((mag * mag) >> 16) * 64'(HALL_KI)) >> 16;
            kpv = (int_sqrt(k << 16) * 64'(HALL_KP)) >> 16;
            hall_kp = clip_u32(kpv);
            hall_ki = clip_u32((k >> 32) * {32'b0, m_ts}
                               + (({32'b0, k[31:0]} * {32'b0, m_ts}) >> 32));
            spd_o = spd_raw;
        end
        else
            spd_o = spd_smooth;
        r.angle = trk_angle;
        r.speed = spd_o[31:0];
        r.err = err[31:0];
        return r;
    endfunction

    function automatic drow_t row(input bit set_cfg, input logic [1:0] mode,
                                  input logic [31:0] kp, input logic [31:0] ki,
                                  input logic [31:0] ts, input logic kind,
                                  input logic [31:0] alpha, input logic [31:0] beta,
                                  input logic [15:0] hangle, input logic [31:0] hspeed,
                                  input bit fixed);
        drow_t r;
        r.set_cfg = set_cfg;
        r.mode = mode;
        r.kp = kp;
        r.ki = ki;
        r.ts = ts;
        r.smp = '{kind, alpha, beta, hangle, hspeed};
        r.fixed = fixed;
        r.want = '0;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_LOOP_MODE:  m_mode = val[1:0];
            REG_PROP_GAIN:  m_kp = val;
            REG_INTEG_GAIN: m_ki = val;
            default:        m_ts = val;
        endcase
    endtask

    task automatic program_loop(input logic [1:0] mode, input logic [31:0] kp,
                                input logic [31:0] ki, input logic [31:0] ts);
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LOOP_MODE, {30'b0, mode});
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_STEP_PERIOD, ts);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input sample_t s, input bit fixed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.kind <= s.kind;
        smp_ch.axis_alpha <= s.alpha;
        smp_ch.axis_beta <= s.beta;
        smp_ch.hall_angle <= s.hangle;
        smp_ch.hall_speed <= s.hspeed;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        predicted = loop_step(s);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default: return $urandom_range(32'h40000);
        endcase
    endfunction

    function automatic sample_t make_sample();
        sample_t s;
        s.kind = ($urandom_range(99) < 3);
        s.hangle = 16'($urandom);
        if ($urandom_range(3) == 0)
        begin
            s.alpha = $urandom;
            s.beta = $urandom;
        end
        else
        begin
            s.alpha = $urandom_range(32'h200000) - 32'h100000;
            s.beta = $urandom_range(32'h200000) - 32'h100000;
        end
        if ($urandom_range(3) == 0)
            s.hspeed = $urandom;
        else
            s.hspeed = $urandom_range(32'h2000000) - 32'h1000000;
        if ($urandom_range(3) != 0)
            s.hangle = trk_angle + 16'($urandom_range(4096)) - 16'd2048;
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: angle %0d speed %0d error %0d",
                           res_ch.angle_out, res_ch.speed_out, res_ch.error_out);
                    fail_count++;
                end
                else
                begin
                    result_t w;
                    w = pending_results.pop_front();
                    if (res_ch.angle_out !== w.angle)
                    begin
                        $error("angle_out: expected %0d, got %0d", w.angle, res_ch.angle_out);
                        fail_count++;
                    end
                    if (res_ch.speed_out !== w.speed)
                    begin
                        $error("speed_out: expected %0d, got %0d", w.speed, res_ch.speed_out);
                        fail_count++;
                    end
                    if (res_ch.error_out !== w.err)
                    begin
                        $error("error_out: expected %0d, got %0d", w.err, res_ch.error_out);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        sample_t s;
        result_t none;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LOOP_MODE;
        cfg_data = '0;
        smp_ch.valid = 1'b0;
        smp_ch.kind = 1'b0;
        smp_ch.axis_alpha = '0;
        smp_ch.axis_beta = '0;
        smp_ch.hall_angle = '0;
        smp_ch.hall_speed = '0;
        res_ch.ready = 1'b0;
        none = '0;
        m_mode = MODE_INJECT;
        m_kp = 0;
        m_ki = 0;
        m_ts = STEP_PERIOD_RST;
        trk_angle = 0;
        integ = 0;
        spd_raw = 0;
        spd_smooth = 0;
        hall_kp = 0;
        hall_ki = 0;

        // zeros after reset, then a clear: both read back all zero
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 32'h7FFFFFFF, 1));
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1));
        dtab.push_back(row(1, MODE_INJECT, 32'h10000, 32'h100, STEP_PERIOD_RST,
                           0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0));
        dtab.push_back(row(1, MODE_INJECT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0));
        dtab.push_back(row(0, MODE_INJECT, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0));
        dtab.push_back(row(1, MODE_EMF, 32'h20000, 32'hFFFFFFFF, 32'd1,
                           0, 32'h00030000, 32'hFFFE0000, 0, 0, 0));
        dtab.push_back(row(0, MODE_EMF, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
        // zero period: angle holds still
        dtab.push_back(row(1, MODE_EMF, 32'h8000, 32'h40000, 32'd0,
                           0, 32'h00100000, 32'h00200000, 0, 0, 0));
        dtab.push_back(row(0, MODE_EMF, 0, 0, 0, 0, 32'hFFF00000, 32'h00010000, 0, 0, 0));
        dtab.push_back(row(1, MODE_HALL, 0, 0, STEP_PERIOD_RST,
                           0, 0, 0, 16'h0000, 32'h7FFFFFFF, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 0, 0, 0, 16'h8000, 32'h80000000, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 0, 0, 0, 16'h8001, 32'h00000000, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 0, 0, 0, 16'hFFFF, 32'h01000000, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 0, 0, 0, 16'h1234, 32'hFF000000, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 1, 0, 0, 16'h4000, 32'h00100000, 0));
        dtab.push_back(row(0, MODE_HALL, 0, 0, 0, 0, 0, 0, 16'h4000, 32'h00100000, 0));
        // spare mode: nothing moves
        dtab.push_back(row(1, MODE_SPARE, 0, 0, STEP_PERIOD_RST,
                           0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hAAAA, 32'h12345678, 0));
        dtab.push_back(row(0, MODE_SPARE, 0, 0, 0, 1, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dtab[i])
        begin
            if (dtab[i].set_cfg)
                program_loop(dtab[i].mode, dtab[i].kp, dtab[i].ki, dtab[i].ts);
            send_request(dtab[i].smp, dtab[i].fixed, dtab[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            logic [31:0] ts;
            case ($urandom_range(4))
                0: ts = 32'd1;
                1: ts = 32'hFFFFFFFF;
                2: ts = $urandom;
                default: ts = STEP_PERIOD_RST;
            endcase
            program_loop(2'(p % 3), pick_gain(), pick_gain(), ts);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                s = make_sample();
                send_request(s, 0, none);
            end
        end

        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* rotor_angle_pll.f */
hdl/rap_pkg.sv
hdl/rap_if.sv
hdl/rap_serial_mul.sv
hdl/rotor_angle_pll.sv
sim/tb.sv
